// ===== sv/amc_pkg.sv =====
// ----------------------------------------------------------------------------
// amc_pkg
// Shared opcodes, status codes and types for the accumulator machine core.
// ----------------------------------------------------------------------------
package amc_pkg;

   // instruction opcodes
   localparam logic [15:0] OP_ADD    = 16'h0001;
   localparam logic [15:0] OP_SUB    = 16'h0002;
   localparam logic [15:0] OP_MUL    = 16'h0003;
   localparam logic [15:0] OP_DIV    = 16'h0004;
   localparam logic [15:0] OP_JMP    = 16'h0005;
   localparam logic [15:0] OP_JMPN   = 16'h0006;
   localparam logic [15:0] OP_JMPP   = 16'h0007;
   localparam logic [15:0] OP_JMPZ   = 16'h0008;
   localparam logic [15:0] OP_COPY   = 16'h0009;
   localparam logic [15:0] OP_LOAD   = 16'h000A;
   localparam logic [15:0] OP_STORE  = 16'h000B;
   localparam logic [15:0] OP_INPUT  = 16'h000C;
   localparam logic [15:0] OP_OUTPUT = 16'h000D;
   localparam logic [15:0] OP_STOP   = 16'h000E;
   localparam logic [15:0] OP_THROW  = 16'h000F;
   localparam logic [15:0] OP_NOP    = 16'h0010;
   localparam logic [15:0] OP_FIRST  = OP_ADD;
   localparam logic [15:0] OP_LAST   = OP_NOP;

   // request kinds
   localparam logic KIND_EXEC    = 1'b0;
   localparam logic KIND_PRELOAD = 1'b1;

   // status codes
   localparam logic [2:0] ST_RUN   = 3'd0;
   localparam logic [2:0] ST_STOP  = 3'd1;
   localparam logic [2:0] ST_THROW = 3'd2;
   localparam logic [2:0] ST_BADOP = 3'd3;
   localparam logic [2:0] ST_DIVZ  = 3'd4;

   // command to the shared multiply / divide unit
   typedef struct packed {
      logic start;
      logic is_div;
   } amc_alu_cmd_type;

endpackage

// ===== sv/amc_alu.sv =====
// ----------------------------------------------------------------------------
// amc_alu
// Shared iterative 16-bit unit: shift-add multiply (low half) and restoring
// signed divide truncating toward zero, one bit per cycle.
// ----------------------------------------------------------------------------
module amc_alu (
   input  logic                     clock,
   input  logic                     reset,
   input  amc_pkg::amc_alu_cmd_type cmd,
   input  logic [15:0]              opnd_a,
   input  logic [15:0]              opnd_b,
   output logic                     done,
   output logic [15:0]              result
);
   import amc_pkg::*;

   typedef enum logic [1:0] {A_IDLE, A_RUN, A_DONE} alu_state_type;

   alu_state_type state_ff, state_in;
   logic [3:0]    cnt_ff, cnt_in;
   logic          is_div_ff, is_div_in;
   logic          neg_ff, neg_in;
   logic [15:0]   x_ff, x_in;
   logic [15:0]   y_ff, y_in;
   logic [16:0]   p_ff, p_in;

   logic [16:0]   shifted;
   logic [16:0]   diff;
   logic [15:0]   mag_a;
   logic [15:0]   mag_b;

   // magnitudes for signed divide
   assign mag_a = opnd_a[15] ? (16'd0 - opnd_a) : opnd_a;
   assign mag_b = opnd_b[15] ? (16'd0 - opnd_b) : opnd_b;

   // one restoring step
   assign shifted = {p_ff[15:0], x_ff[15]};
   assign diff    = shifted - {1'b0, y_ff};

   // next state
   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      is_div_in = is_div_ff;
      neg_in    = neg_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      p_in      = p_ff;
      unique case (state_ff)
         A_IDLE: begin
            if (cmd.start) begin
               state_in  = A_RUN;
               cnt_in    = 4'd0;
               is_div_in = cmd.is_div;
               neg_in    = opnd_a[15] ^ opnd_b[15];
               p_in      = 17'd0;
               if (cmd.is_div) begin
                  x_in = mag_a;
                  y_in = mag_b;
               end else begin
                  x_in = opnd_b;
                  y_in = opnd_a;
               end
            end
         end
         A_RUN: begin
            if (is_div_ff) begin
               if (!diff[16]) begin
                  p_in = diff;
                  x_in = {x_ff[14:0], 1'b1};
               end else begin
                  p_in = shifted;
                  x_in = {x_ff[14:0], 1'b0};
               end
            end else begin
               if (x_ff[0]) begin
                  p_in = {1'b0, p_ff[15:0] + y_ff};
               end
               x_in = {1'b0, x_ff[15:1]};
               y_in = {y_ff[14:0], 1'b0};
            end
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd15) begin
               state_in = A_DONE;
            end
         end
         A_DONE: begin
            state_in = A_IDLE;
         end
         default: begin
            state_in = A_IDLE;
         end
      endcase
   end

   // state and datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= A_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cnt_ff    <= cnt_in;
      is_div_ff <= is_div_in;
      neg_ff    <= neg_in;
      x_ff      <= x_in;
      y_ff      <= y_in;
      p_ff      <= p_in;
   end

   // result, signed fixup for divide
   assign done   = (state_ff == A_DONE);
   assign result = is_div_ff ? (neg_ff ? (16'd0 - x_ff) : x_ff) : p_ff[15:0];

endmodule

// ===== sv/amc_dmem.sv =====
// ----------------------------------------------------------------------------
// amc_dmem
// Data memory with one write and one registered read port. Addresses at or
// above the depth read as zero and ignore writes. Cleared after reset.
// ----------------------------------------------------------------------------
module amc_dmem #(
   parameter int DATA_DEPTH = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [15:0] rd_addr,
   output logic [15:0] rd_data,
   input  logic        wr_en,
   input  logic [15:0] wr_addr,
   input  logic [15:0] wr_data,
   output logic        clearing
);
   localparam int AW = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1;

   logic [15:0]   mem [DATA_DEPTH];
   logic [15:0]   rd_data_ff;
   logic          rd_hit_ff;
   logic          clr_ff;
   logic [AW-1:0] clr_cnt_ff;

   logic          rd_hit;
   logic          wr_hit;
   logic          we;
   logic [AW-1:0] we_idx;
   logic [15:0]   we_data;

   // range checks
   assign rd_hit = ({1'b0, rd_addr} < 17'(DATA_DEPTH));
   assign wr_hit = ({1'b0, wr_addr} < 17'(DATA_DEPTH));

   // clearing pass owns the write port
   assign we      = clr_ff | (wr_en & wr_hit);
   assign we_idx  = clr_ff ? clr_cnt_ff : wr_addr[AW-1:0];
   assign we_data = clr_ff ? 16'd0 : wr_data;

   // clear sweep control
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff     <= 1'b1;
         clr_cnt_ff <= '0;
      end else if (clr_ff) begin
         clr_cnt_ff <= clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == AW'(DATA_DEPTH - 1)) begin
            clr_ff <= 1'b0;
         end
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (we) begin
         mem[we_idx] <= we_data;
      end
      rd_data_ff <= mem[rd_addr[AW-1:0]];
      rd_hit_ff  <= rd_hit;
   end

   assign rd_data  = rd_hit_ff ? rd_data_ff : 16'd0;
   assign clearing = clr_ff;

endmodule

// ===== sv/accumulator_machine_core.sv =====
// ----------------------------------------------------------------------------
// accumulator_machine_core
// 16-bit accumulator machine executing one instruction per request.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one request: an instruction (kind 0) with the opcode word
//   fetched at rsp_next_pc, its operand words and an INPUT value, or a data
//   preload (kind 1, address in operand_a, value in operand_b). A request is
//   taken on an edge with req_valid high and req_stall low.
//   rsp_* returns exactly one result per request: new program counter,
//   accumulator, OUTPUT word and status.
// Timing:
//   req_stall stays high while a request is in flight; one request is
//   handled at a time. Preloads, halted and invalid-opcode requests go to
//   S_FIN at once; other instructions pass S_READ and S_EXEC, then MUL and
//   DIV (not by zero) wait in S_ITER while the shared multiply/divide unit
//   resolves one bit per cycle; the result is valid when S_IDLE is reentered.
// Reset:
//   synchronous; accumulator, program counter and halt state clear, and the
//   data memory is swept to zero with req_stall high.
// Backpressure:
//   the result sits in an output register until rsp_stall drops; a new request
//   is still taken, and its result waits in S_FIN until the register is free.
// ----------------------------------------------------------------------------
module accumulator_machine_core #(
   parameter int DATA_DEPTH = 1024
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_kind,
   input  logic [15:0]        req_opcode,
   input  logic [15:0]        req_operand_a,
   input  logic [15:0]        req_operand_b,
   input  logic signed [15:0] req_input_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [15:0]        rsp_next_pc,
   output logic signed [15:0] rsp_acc_value,
   output logic               rsp_out_valid,
   output logic signed [15:0] rsp_out_value,
   output logic [2:0]         rsp_status
);
   import amc_pkg::*;

   typedef enum logic [2:0] {S_IDLE, S_READ, S_EXEC, S_ITER, S_FIN} seq_state_type;

   seq_state_type state_ff, state_in;
   logic [15:0]   op_ff, op_in;
   logic [15:0]   a_ff, a_in;
   logic [15:0]   b_ff, b_in;
   logic [15:0]   inval_ff, inval_in;
   logic [15:0]   acc_ff, acc_in;
   logic [15:0]   pc_ff, pc_in;
   logic          halted_ff, halted_in;
   logic [2:0]    cause_ff, cause_in;
   logic          ovalid_ff, ovalid_in;
   logic [15:0]   oval_ff, oval_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [15:0]   rsp_pc_ff, rsp_pc_in;
   logic [15:0]   rsp_acc_ff, rsp_acc_in;
   logic          rsp_ovalid_ff, rsp_ovalid_in;
   logic [15:0]   rsp_oval_ff, rsp_oval_in;
   logic [2:0]    rsp_status_ff, rsp_status_in;

   logic            req_take;
   logic            mem_clearing;
   logic [15:0]     mem_rd_data;
   logic            mem_wr_en;
   logic [15:0]     mem_wr_addr;
   logic [15:0]     mem_wr_data;
   amc_alu_cmd_type alu_cmd;
   logic            alu_done;
   logic [15:0]     alu_result;
   logic            op_bad;

   assign req_take = req_valid & ~req_stall;
   assign op_bad   = (req_opcode < OP_FIRST) || (req_opcode > OP_LAST);

   // data memory
   amc_dmem #(
      .DATA_DEPTH (DATA_DEPTH)
   ) u_dmem (
      .clock    (clock),
      .reset    (reset),
      .rd_addr  (a_ff),
      .rd_data  (mem_rd_data),
      .wr_en    (mem_wr_en),
      .wr_addr  (mem_wr_addr),
      .wr_data  (mem_wr_data),
      .clearing (mem_clearing)
   );

   // shared multiply / divide unit
   amc_alu u_alu (
      .clock  (clock),
      .reset  (reset),
      .cmd    (alu_cmd),
      .opnd_a (acc_ff),
      .opnd_b (mem_rd_data),
      .done   (alu_done),
      .result (alu_result)
   );

   // memory writes and unit start
   always_comb begin
      mem_wr_en      = 1'b0;
      mem_wr_addr    = a_ff;
      mem_wr_data    = acc_ff;
      alu_cmd.start  = 1'b0;
      alu_cmd.is_div = (op_ff == OP_DIV);
      if (state_ff == S_IDLE) begin
         mem_wr_en   = req_take & (req_kind == KIND_PRELOAD);
         mem_wr_addr = req_operand_a;
         mem_wr_data = req_operand_b;
      end else if (state_ff == S_EXEC) begin
         unique case (op_ff)
            OP_COPY: begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = b_ff;
               mem_wr_data = mem_rd_data;
            end
            OP_STORE: begin
               mem_wr_en = 1'b1;
            end
            OP_INPUT: begin
               mem_wr_en   = 1'b1;
               mem_wr_data = inval_ff;
            end
            OP_MUL: begin
               alu_cmd.start = 1'b1;
            end
            OP_DIV: begin
               alu_cmd.start = (mem_rd_data != 16'd0);
            end
            default: begin
            end
         endcase
      end
   end

   // sequencer next state
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      inval_in      = inval_ff;
      acc_in        = acc_ff;
      pc_in         = pc_ff;
      halted_in     = halted_ff;
      cause_in      = cause_ff;
      ovalid_in     = ovalid_ff;
      oval_in       = oval_ff;
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      rsp_pc_in     = rsp_pc_ff;
      rsp_acc_in    = rsp_acc_ff;
      rsp_ovalid_in = rsp_ovalid_ff;
      rsp_oval_in   = rsp_oval_ff;
      rsp_status_in = rsp_status_ff;
      unique case (state_ff)
         // take a request
         S_IDLE: begin
            if (req_take) begin
               op_in     = req_opcode;
               a_in      = req_operand_a;
               b_in      = req_operand_b;
               inval_in  = $unsigned(req_input_value);
               ovalid_in = 1'b0;
               oval_in   = 16'd0;
               if (req_kind == KIND_PRELOAD || halted_ff) begin
                  state_in = S_FIN;
               end else if (op_bad) begin
                  halted_in = 1'b1;
                  cause_in  = ST_BADOP;
                  state_in  = S_FIN;
               end else begin
                  state_in = S_READ;
               end
            end
         end
         // operand read in flight
         S_READ: begin
            state_in = S_EXEC;
         end
         // execute with the operand word
         S_EXEC: begin
            state_in = S_FIN;
            pc_in    = pc_ff + 16'd2;
            unique case (op_ff)
               OP_ADD: acc_in = acc_ff + mem_rd_data;
               OP_SUB: acc_in = acc_ff - mem_rd_data;
               OP_MUL: begin
                  pc_in    = pc_ff;
                  state_in = S_ITER;
               end
               OP_DIV: begin
                  pc_in = pc_ff;
                  if (mem_rd_data == 16'd0) begin
                     halted_in = 1'b1;
                     cause_in  = ST_DIVZ;
                  end else begin
                     state_in = S_ITER;
                  end
               end
               OP_JMP: pc_in = a_ff;
               OP_JMPN: begin
                  if (acc_ff[15]) begin
                     pc_in = a_ff;
                  end
               end
               OP_JMPP: begin
                  if (!acc_ff[15] && acc_ff != 16'd0) begin
                     pc_in = a_ff;
                  end
               end
               OP_JMPZ: begin
                  if (acc_ff == 16'd0) begin
                     pc_in = a_ff;
                  end
               end
               OP_COPY: pc_in = pc_ff + 16'd3;
               OP_LOAD: acc_in = mem_rd_data;
               OP_STORE, OP_INPUT: begin
               end
               OP_OUTPUT: begin
                  ovalid_in = 1'b1;
                  oval_in   = mem_rd_data;
               end
               OP_STOP: begin
                  pc_in     = pc_ff;
                  halted_in = 1'b1;
                  cause_in  = ST_STOP;
               end
               OP_THROW: begin
                  pc_in     = pc_ff;
                  halted_in = 1'b1;
                  cause_in  = ST_THROW;
               end
               default: pc_in = pc_ff + 16'd1;
            endcase
         end
         // wait for the shared unit
         S_ITER: begin
            if (alu_done) begin
               acc_in   = alu_result;
               pc_in    = pc_ff + 16'd2;
               state_in = S_FIN;
            end
         end
         // hand the result to the output register
         S_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_pc_in     = pc_ff;
               rsp_acc_in    = acc_ff;
               rsp_ovalid_in = ovalid_ff;
               rsp_oval_in   = oval_ff;
               rsp_status_in = halted_ff ? cause_ff : ST_RUN;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         acc_ff       <= 16'd0;
         pc_ff        <= 16'd0;
         halted_ff    <= 1'b0;
         cause_ff     <= ST_RUN;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         pc_ff        <= pc_in;
         halted_ff    <= halted_in;
         cause_ff     <= cause_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      inval_ff      <= inval_in;
      ovalid_ff     <= ovalid_in;
      oval_ff       <= oval_in;
      rsp_pc_ff     <= rsp_pc_in;
      rsp_acc_ff    <= rsp_acc_in;
      rsp_ovalid_ff <= rsp_ovalid_in;
      rsp_oval_ff   <= rsp_oval_in;
      rsp_status_ff <= rsp_status_in;
   end

   // ports
   assign req_stall     = (state_ff != S_IDLE) | mem_clearing;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_next_pc   = rsp_pc_ff;
   assign rsp_acc_value = $signed(rsp_acc_ff);
   assign rsp_out_valid = rsp_ovalid_ff;
   assign rsp_out_value = $signed(rsp_oval_ff);
   assign rsp_status    = rsp_status_ff;

endmodule
